@@ rtl/dnsp_pkg.sv @@
package dnsp_pkg;

  // Parser phases
  localparam logic [3:0] PH_HEADER   = 4'd0;
  localparam logic [3:0] PH_NAME_LEN = 4'd1;
  localparam logic [3:0] PH_PTR2     = 4'd2;
  localparam logic [3:0] PH_LABEL    = 4'd3;
  localparam logic [3:0] PH_TYPE     = 4'd4;
  localparam logic [3:0] PH_CLASS    = 4'd5;
  localparam logic [3:0] PH_TTL      = 4'd6;
  localparam logic [3:0] PH_RDLEN    = 4'd7;
  localparam logic [3:0] PH_RDATA    = 4'd8;
  localparam logic [3:0] PH_DONE     = 4'd9;

  // Sections
  localparam logic [2:0] SEC_HEADER     = 3'd0;
  localparam logic [2:0] SEC_QUESTION   = 3'd1;
  localparam logic [2:0] SEC_ANSWER     = 3'd2;
  localparam logic [2:0] SEC_ADDITIONAL = 3'd4;
  localparam logic [2:0] SEC_AFTER      = 3'd5;

  // Field kinds
  localparam logic [3:0] KIND_COUNT_FIRST = 4'd2;
  localparam logic [3:0] KIND_COUNT_LAST  = 4'd5;
  localparam logic [3:0] KIND_LABEL_LEN   = 4'd6;
  localparam logic [3:0] KIND_LABEL_BYTE  = 4'd7;
  localparam logic [3:0] KIND_NAME_END    = 4'd8;
  localparam logic [3:0] KIND_POINTER     = 4'd9;
  localparam logic [3:0] KIND_TYPE        = 4'd10;
  localparam logic [3:0] KIND_RDATA       = 4'd14;
  localparam logic [3:0] KIND_TRAILING    = 4'd15;

  // Status codes
  localparam logic [1:0] STAT_PARSING  = 2'd0;
  localparam logic [1:0] STAT_COMPLETE = 2'd1;
  localparam logic [1:0] STAT_TRUNC    = 2'd2;
  localparam logic [1:0] STAT_SHORT    = 2'd3;

  localparam logic [1:0] PTR_MARK      = 2'b11;
  localparam logic [3:0] HEADER_BYTES  = 4'd12;
  localparam logic [2:0] TTL_BYTES     = 3'd4;
  localparam logic [2:0] SHORT_BYTES   = 3'd2;

  // Record types whose rdata holds a domain name
  localparam logic [31:0] RR_NS    = 32'd2;
  localparam logic [31:0] RR_CNAME = 32'd5;
  localparam logic [31:0] RR_SOA   = 32'd6;
  localparam logic [31:0] RR_PTR   = 32'd12;
  localparam logic [31:0] RR_MX    = 32'd15;

  typedef struct packed {
    logic [3:0]       phase;
    logic [2:0]       byte_in_field;
    logic [15:0]      bytes_left;
    logic [31:0]      acc;
    logic [3:0][15:0] counts;
    logic [2:0]       section;
    logic [15:0]      record;
    logic [3:0]       header_pos;
    logic             name_flag;
    logic             finished;
  } state_t;

  localparam state_t STATE_RESET = '0;

  typedef struct packed {
    logic [2:0]  section;
    logic [15:0] record_index;
    logic [3:0]  field_kind;
    logic        field_done;
    logic [31:0] field_value;
    logic        rdata_is_name;
    logic [1:0]  status;
  } result_t;

endpackage

@@ rtl/dnsp_step.sv @@
module dnsp_step (
  input  dnsp_pkg::state_t  cur,
  input  logic [7:0]        in_byte,
  input  logic              last_byte,
  output dnsp_pkg::state_t  nxt,
  output dnsp_pkg::result_t res
);

  dnsp_pkg::state_t mid;
  logic        begin_req;
  logic [2:0]  begin_from;
  logic        end_rec;
  logic        found;
  logic [15:0] acc16;
  logic [31:0] acc_sh;
  logic [2:0]  bif_inc;
  logic [2:0]  need;
  logic [15:0] bl_dec;
  logic [3:0]  hp_inc;
  logic [1:0]  cnt_idx;
  logic [16:0] rec_inc;
  logic        fin_nxt;

  always_comb begin
    mid        = cur;
    begin_req  = 1'b0;
    begin_from = dnsp_pkg::SEC_QUESTION;
    end_rec    = 1'b0;
    found      = 1'b0;
    acc16      = {cur.acc[7:0], in_byte};
    acc_sh     = {cur.acc[23:0], in_byte};
    bif_inc    = cur.byte_in_field + 3'd1;
    need       = (cur.phase == dnsp_pkg::PH_TTL) ? dnsp_pkg::TTL_BYTES
                                                 : dnsp_pkg::SHORT_BYTES;
    bl_dec     = (cur.bytes_left != 16'd0) ? cur.bytes_left - 16'd1 : cur.bytes_left;
    hp_inc     = cur.header_pos + 4'd1;
    cnt_idx    = 2'(cur.section - 3'd1);
    rec_inc    = {1'b0, cur.record} + 17'd1;

    res.section       = cur.section;
    res.record_index  = cur.record;
    res.field_kind    = 4'd0;
    res.field_done    = 1'b0;
    res.field_value   = 32'd0;
    res.rdata_is_name = 1'b0;
    res.status        = dnsp_pkg::STAT_PARSING;

    case (cur.phase)
      dnsp_pkg::PH_HEADER: begin
        res.field_kind = {1'b0, cur.header_pos[3:1]};
        mid.header_pos = hp_inc;
        if (cur.header_pos[0]) begin
          res.field_done  = 1'b1;
          res.field_value = {16'd0, acc16};
          mid.acc         = 32'd0;
          for (int i = 0; i < 4; i++) begin
            if (res.field_kind == dnsp_pkg::KIND_COUNT_FIRST + 4'(i)) begin
              mid.counts[i] = acc16;
            end
          end
        end else begin
          mid.acc = {16'd0, acc16};
        end
        if (hp_inc >= dnsp_pkg::HEADER_BYTES) begin
          begin_req = 1'b1;
        end
      end
      dnsp_pkg::PH_NAME_LEN: begin
        if (in_byte == 8'd0) begin
          res.field_kind    = dnsp_pkg::KIND_NAME_END;
          res.field_done    = 1'b1;
          mid.phase         = dnsp_pkg::PH_TYPE;
          mid.byte_in_field = 3'd0;
          mid.acc           = 32'd0;
        end else if (in_byte[7:6] == dnsp_pkg::PTR_MARK) begin
          res.field_kind = dnsp_pkg::KIND_POINTER;
          mid.acc        = {24'd0, in_byte};
          mid.phase      = dnsp_pkg::PH_PTR2;
        end else begin
          res.field_kind  = dnsp_pkg::KIND_LABEL_LEN;
          res.field_done  = 1'b1;
          res.field_value = {24'd0, in_byte};
          mid.bytes_left  = {8'd0, in_byte};
          mid.phase       = dnsp_pkg::PH_LABEL;
        end
      end
      dnsp_pkg::PH_PTR2: begin
        res.field_kind    = dnsp_pkg::KIND_POINTER;
        res.field_done    = 1'b1;
        res.field_value   = {18'd0, cur.acc[5:0], in_byte};
        mid.acc           = 32'd0;
        mid.byte_in_field = 3'd0;
        mid.phase         = dnsp_pkg::PH_TYPE;
      end
      dnsp_pkg::PH_LABEL: begin
        res.field_kind  = dnsp_pkg::KIND_LABEL_BYTE;
        res.field_done  = 1'b1;
        res.field_value = {24'd0, in_byte};
        mid.bytes_left  = bl_dec;
        if (bl_dec == 16'd0) begin
          mid.phase = dnsp_pkg::PH_NAME_LEN;
        end
      end
      dnsp_pkg::PH_TYPE, dnsp_pkg::PH_CLASS, dnsp_pkg::PH_TTL, dnsp_pkg::PH_RDLEN: begin
        res.field_kind = dnsp_pkg::KIND_TYPE + (cur.phase - dnsp_pkg::PH_TYPE);
        if (bif_inc >= need) begin
          res.field_done    = 1'b1;
          res.field_value   = acc_sh;
          mid.acc           = 32'd0;
          mid.byte_in_field = 3'd0;
          case (cur.phase)
            dnsp_pkg::PH_TYPE: begin
              if (cur.section >= dnsp_pkg::SEC_ANSWER) begin
                mid.name_flag = (acc_sh == dnsp_pkg::RR_NS) || (acc_sh == dnsp_pkg::RR_CNAME) ||
                                (acc_sh == dnsp_pkg::RR_SOA) || (acc_sh == dnsp_pkg::RR_PTR) ||
                                (acc_sh == dnsp_pkg::RR_MX);
              end
              mid.phase = dnsp_pkg::PH_CLASS;
            end
            dnsp_pkg::PH_CLASS: begin
              if (cur.section == dnsp_pkg::SEC_QUESTION) begin
                end_rec = 1'b1;
              end else begin
                mid.phase = dnsp_pkg::PH_TTL;
              end
            end
            dnsp_pkg::PH_TTL: begin
              mid.phase = dnsp_pkg::PH_RDLEN;
            end
            default: begin
              mid.bytes_left = acc_sh[15:0];
              if (acc_sh == 32'd0) begin
                end_rec = 1'b1;
              end else begin
                mid.phase = dnsp_pkg::PH_RDATA;
              end
            end
          endcase
        end else begin
          mid.acc           = acc_sh;
          mid.byte_in_field = bif_inc;
        end
      end
      dnsp_pkg::PH_RDATA: begin
        res.field_kind  = dnsp_pkg::KIND_RDATA;
        res.field_done  = 1'b1;
        res.field_value = {24'd0, in_byte};
        mid.bytes_left  = bl_dec;
        if (bl_dec == 16'd0) begin
          end_rec = 1'b1;
        end
      end
      default: begin
        res.section      = dnsp_pkg::SEC_AFTER;
        res.record_index = 16'd0;
        res.field_kind   = dnsp_pkg::KIND_TRAILING;
      end
    endcase

    if (!cur.finished && res.section >= dnsp_pkg::SEC_ANSWER &&
        res.section <= dnsp_pkg::SEC_ADDITIONAL) begin
      res.rdata_is_name = mid.name_flag;
    end

    // Close the record: next record of this section, or move on
    if (end_rec) begin
      if (cur.section >= dnsp_pkg::SEC_QUESTION && cur.section <= dnsp_pkg::SEC_ADDITIONAL) begin
        if (rec_inc < {1'b0, mid.counts[cnt_idx]}) begin
          mid.record    = rec_inc[15:0];
          mid.phase     = dnsp_pkg::PH_NAME_LEN;
          mid.name_flag = 1'b0;
        end else begin
          begin_req  = 1'b1;
          begin_from = cur.section + 3'd1;
        end
      end else begin
        begin_req  = 1'b1;
        begin_from = dnsp_pkg::SEC_AFTER;
      end
    end

    // Skip empty sections
    if (begin_req) begin
      mid.record    = 16'd0;
      mid.name_flag = 1'b0;
      for (int s = 1; s <= 4; s++) begin
        if (!found && 3'(s) >= begin_from && mid.counts[s-1] != 16'd0) begin
          found       = 1'b1;
          mid.section = 3'(s);
          mid.phase   = dnsp_pkg::PH_NAME_LEN;
        end
      end
      if (!found) begin
        mid.section  = dnsp_pkg::SEC_AFTER;
        mid.phase    = dnsp_pkg::PH_DONE;
        mid.finished = 1'b1;
      end
    end

    fin_nxt = mid.finished;
    if (cur.finished || fin_nxt) begin
      res.status = dnsp_pkg::STAT_COMPLETE;
    end else if (last_byte) begin
      res.status = (mid.phase == dnsp_pkg::PH_HEADER) ? dnsp_pkg::STAT_SHORT
                                                      : dnsp_pkg::STAT_TRUNC;
    end

    nxt = last_byte ? dnsp_pkg::STATE_RESET : mid;
  end

endmodule

@@ rtl/dns_message_byte_parser_core.sv @@
// Output: a byte accepted at a clock edge shows its result word on out_* after that same edge,
//   computed from the parse state register and loaded into the result register.
// Throughput: one byte per cycle; in_tready stays high while the result register is empty
//   or is being drained in the same cycle.
// Reset: synchronous, active low; clears the parse state to the header phase and empties
//   the result register. A byte with in_tlast set returns the parser to that same state.
module dns_message_byte_parser_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [15:0] record_index, [47:16] field_value
  output logic [10:0] out_tuser   // [2:0] section, [6:3] field_kind, [7] field_done,
                                  // [8] rdata_is_name, [10:9] status
);

  // Parse state: header position, phase within a record, counts, record index
  dnsp_pkg::state_t  state_r;
  dnsp_pkg::state_t  state_nxt;
  dnsp_pkg::result_t step_res;

  logic        out_tvalid_r;
  logic [47:0] out_tdata_r;
  logic [10:0] out_tuser_r;
  logic        in_fire;

  // Take a new byte whenever the result register is free or drains this cycle
  assign in_tready = !out_tvalid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  // Whole per-byte update: decode the byte against the state in one pass
  dnsp_step u_step (
    .cur       (state_r),
    .in_byte   (in_tdata),
    .last_byte (in_tlast),
    .nxt       (state_nxt),
    .res       (step_res)
  );

  // Advance the parse state only on an accepted byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dnsp_pkg::STATE_RESET;
    end else if (in_fire) begin
      state_r <= state_nxt;
    end
  end

  // Result register: load on accept, drop valid once the word is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (in_fire) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  // Payload holds while stalled; no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_tdata_r <= {step_res.field_value, step_res.record_index};
      out_tuser_r <= {step_res.status, step_res.rdata_is_name, step_res.field_done,
                      step_res.field_kind, step_res.section};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule
